>>> sv/assert_macros.svh
// Assertion macros shared by the RLE row encoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Same-cycle implication check failed.");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Next-cycle implication check failed.");

`endif

>>> sv/br1_pkg.sv
// Shared types and constants of the ByteRun1 row encoder.
// Depends on nothing; used by every module of the encoder.
package br1_pkg;

  localparam int BYTES_PER_GROUP_DEF = 8;
  localparam int GROUP_MAX = 8;
  localparam int CHUNK_MAX = 128;
  localparam int STORE_AW = $clog2(CHUNK_MAX);
  localparam int LCOUNT_W = $clog2(CHUNK_MAX + 1);
  localparam int CMD_DEPTH = 4;

  // One classified input byte: the ordered list of operations it causes.
  typedef struct packed {
    logic                flush_mid;
    logic                rep_en;
    logic [LCOUNT_W-1:0] rep_n;
    logic [7:0]          rep_v;
    logic [1:0]          num_a;
    logic [7:0]          val_a;
    logic [1:0]          num_b;
    logic [7:0]          val_b;
    logic                flush_end;
    logic                row_done;
  } cmd_t;

  // One code byte, or the end mark of an input transaction.
  typedef struct packed {
    logic       is_end;
    logic       row_done;
    logic [7:0] value;
  } token_t;

endpackage

>>> sv/br1_byte_if.sv
// Input channel of the ByteRun1 row encoder: one raw row byte per transaction.
// Depends on nothing.
interface br1_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       row_last;

  modport source(output valid, data_byte, row_last, input ready);
  modport sink(input valid, data_byte, row_last, output ready);
endinterface

>>> sv/br1_group_if.sv
// Output channel of the ByteRun1 row encoder: one group of code bytes per transaction.
// Depends on nothing.
interface br1_group_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte_0;
  logic [7:0] out_byte_1;
  logic [7:0] out_byte_2;
  logic [7:0] out_byte_3;
  logic [7:0] out_byte_4;
  logic [7:0] out_byte_5;
  logic [7:0] out_byte_6;
  logic [7:0] out_byte_7;
  logic [3:0] byte_count;
  logic       group_last;
  logic       row_done;

  modport source(output valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_byte_4,
                 out_byte_5, out_byte_6, out_byte_7, byte_count, group_last, row_done,
                 input ready);
  modport sink(input valid, out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_byte_4,
               out_byte_5, out_byte_6, out_byte_7, byte_count, group_last, row_done,
               output ready);
endinterface

>>> sv/br1_front.sv
// Front end: tracks run state per row byte and turns each byte into one command.
// Depends on br1_pkg and br1_byte_if.
module br1_front (
  input  logic           clk,
  input  logic           rst,
  br1_byte_if.sink       row_bytes,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output br1_pkg::cmd_t  cmd
);
  import br1_pkg::*;

  logic                row_started, row_started_next;
  logic                repeat_mode, repeat_mode_next;
  logic [1:0]          pending, pending_next;
  logic [7:0]          prev_byte, prev_byte_next;
  logic [LCOUNT_W-1:0] rcount, rcount_next;
  logic [7:0]          rvalue, rvalue_next;
  logic [7:0]          b;
  logic                last;
  logic [LCOUNT_W-1:0] rcount_inc;

  assign b          = row_bytes.data_byte;
  assign last       = row_bytes.row_last;
  assign rcount_inc = rcount + LCOUNT_W'(1);
  assign cmd_valid  = row_bytes.valid;
  assign row_bytes.ready = cmd_ready;

  always_comb begin
    cmd              = '0;
    cmd.row_done     = last;
    row_started_next = row_started;
    repeat_mode_next = repeat_mode;
    pending_next     = pending;
    rcount_next      = rcount;
    rvalue_next      = rvalue;
    prev_byte_next   = b;

    priority if (!row_started) begin
      row_started_next = 1'b1;
      repeat_mode_next = 1'b0;
      pending_next     = 2'd1;
      rcount_next      = '0;
    end else if (repeat_mode) begin
      if (b == rvalue) begin
        if (rcount_inc == LCOUNT_W'(CHUNK_MAX)) begin
          cmd.rep_en  = 1'b1;
          cmd.rep_n   = rcount_inc;
          cmd.rep_v   = rvalue;
          rcount_next = '0;
        end else begin
          rcount_next = rcount_inc;
        end
      end else begin
        cmd.rep_en       = (rcount != '0);
        cmd.rep_n        = rcount;
        cmd.rep_v        = rvalue;
        rcount_next      = '0;
        repeat_mode_next = 1'b0;
        pending_next     = 2'd1;
      end
    end else if (b != prev_byte) begin
      cmd.num_a    = pending;
      cmd.val_a    = prev_byte;
      pending_next = 2'd1;
    end else if (pending < 2'd2) begin
      pending_next = pending + 2'd1;
    end else begin
      cmd.flush_mid    = 1'b1;
      pending_next     = 2'd0;
      repeat_mode_next = 1'b1;
      rcount_next      = LCOUNT_W'(3);
      rvalue_next      = b;
    end

    if (last) begin
      if (repeat_mode_next) begin
        if (rcount_next != '0) begin
          cmd.rep_en = 1'b1;
          cmd.rep_n  = rcount_next;
          cmd.rep_v  = rvalue_next;
        end
      end else begin
        cmd.num_b     = pending_next;
        cmd.val_b     = b;
        cmd.flush_end = 1'b1;
      end
      row_started_next = 1'b0;
      repeat_mode_next = 1'b0;
      pending_next     = 2'd0;
      rcount_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_started <= 1'b0;
      repeat_mode <= 1'b0;
      pending     <= 2'd0;
      prev_byte   <= 8'h00;
      rcount      <= '0;
      rvalue      <= 8'h00;
    end else if (row_bytes.valid && cmd_ready) begin
      row_started <= row_started_next;
      repeat_mode <= repeat_mode_next;
      pending     <= pending_next;
      prev_byte   <= prev_byte_next;
      rcount      <= rcount_next;
      rvalue      <= rvalue_next;
    end
  end

endmodule

>>> sv/br1_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on br1_pkg.
module br1_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  br1_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output br1_pkg::cmd_t pop_data
);
  import br1_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int FW = $clog2(CMD_DEPTH + 1);

  cmd_t          entry [CMD_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != FW'(CMD_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/br1_back.sv
// Back end: executes commands, keeps the literal store and sends out code bytes.
// Depends on br1_pkg.
module br1_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  br1_pkg::cmd_t   cmd_in,
  output logic            tok_valid,
  input  logic            tok_ready,
  output br1_pkg::token_t tok
);
  import br1_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MID   = 4'd1;
  localparam logic [3:0] S_REP_H = 4'd2;
  localparam logic [3:0] S_REP_V = 4'd3;
  localparam logic [3:0] S_COM_A = 4'd4;
  localparam logic [3:0] S_COM_B = 4'd5;
  localparam logic [3:0] S_FEND  = 4'd6;
  localparam logic [3:0] S_LIT_H = 4'd7;
  localparam logic [3:0] S_LIT_D = 4'd8;
  localparam logic [3:0] S_END   = 4'd9;

  logic [3:0]          state, state_next;
  logic [3:0]          ret_state, ret_state_next;
  cmd_t                cmd, cmd_next;
  logic [LCOUNT_W-1:0] lcount, lcount_next;
  logic [STORE_AW-1:0] idx, idx_next;
  logic [7:0]          store [CHUNK_MAX];
  logic [7:0]          rd_data;
  logic                we;
  logic [STORE_AW-1:0] waddr;
  logic [7:0]          wdata;
  logic                re;
  logic [STORE_AW-1:0] raddr;
  logic [LCOUNT_W-1:0] lcount_inc;
  logic [LCOUNT_W-1:0] lcount_dec;

  assign lcount_inc = lcount + LCOUNT_W'(1);
  assign lcount_dec = lcount - LCOUNT_W'(1);

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    cmd_next       = cmd;
    lcount_next    = lcount;
    idx_next       = idx;
    cmd_ready      = 1'b0;
    tok_valid      = 1'b0;
    tok            = '0;
    we             = 1'b0;
    waddr          = lcount[STORE_AW-1:0];
    wdata          = cmd.val_a;
    re             = 1'b0;
    raddr          = idx;

    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_next   = cmd_in;
          state_next = S_MID;
        end
      end
      S_MID: begin
        if (cmd.flush_mid && lcount != '0) begin
          state_next     = S_LIT_H;
          ret_state_next = S_REP_H;
        end else begin
          state_next = S_REP_H;
        end
      end
      S_REP_H: begin
        if (!cmd.rep_en) begin
          state_next = S_COM_A;
        end else begin
          tok_valid = 1'b1;
          tok.value = 8'(LCOUNT_W'(1) - cmd.rep_n);
          if (tok_ready) begin
            state_next = S_REP_V;
          end
        end
      end
      S_REP_V: begin
        tok_valid = 1'b1;
        tok.value = cmd.rep_v;
        if (tok_ready) begin
          state_next = S_COM_A;
        end
      end
      S_COM_A: begin
        if (cmd.num_a == 2'd0) begin
          state_next = S_COM_B;
        end else begin
          we             = 1'b1;
          wdata          = cmd.val_a;
          lcount_next    = lcount_inc;
          cmd_next.num_a = cmd.num_a - 2'd1;
          if (lcount_inc == LCOUNT_W'(CHUNK_MAX)) begin
            state_next     = S_LIT_H;
            ret_state_next = S_COM_A;
          end
        end
      end
      S_COM_B: begin
        if (cmd.num_b == 2'd0) begin
          state_next = S_FEND;
        end else begin
          we             = 1'b1;
          wdata          = cmd.val_b;
          lcount_next    = lcount_inc;
          cmd_next.num_b = cmd.num_b - 2'd1;
          if (lcount_inc == LCOUNT_W'(CHUNK_MAX)) begin
            state_next     = S_LIT_H;
            ret_state_next = S_COM_B;
          end
        end
      end
      S_FEND: begin
        if (cmd.flush_end && lcount != '0) begin
          state_next     = S_LIT_H;
          ret_state_next = S_END;
        end else begin
          state_next = S_END;
        end
      end
      S_LIT_H: begin
        tok_valid = 1'b1;
        tok.value = 8'(lcount_dec);
        if (tok_ready) begin
          re         = 1'b1;
          raddr      = '0;
          idx_next   = '0;
          state_next = S_LIT_D;
        end
      end
      S_LIT_D: begin
        tok_valid = 1'b1;
        tok.value = rd_data;
        if (tok_ready) begin
          if (LCOUNT_W'(idx) == lcount_dec) begin
            lcount_next = '0;
            state_next  = ret_state;
          end else begin
            idx_next = idx + STORE_AW'(1);
            re       = 1'b1;
            raddr    = idx + STORE_AW'(1);
          end
        end
      end
      S_END: begin
        tok_valid    = 1'b1;
        tok.is_end   = 1'b1;
        tok.row_done = cmd.row_done;
        if (tok_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      lcount    <= '0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      lcount    <= lcount_next;
      idx       <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= store[raddr];
    end
  end

endmodule

>>> sv/br1_packer.sv
// Packs the code byte stream into output groups and holds the output register.
// Depends on br1_pkg and br1_group_if.
module br1_packer #(
  parameter int GROUP = br1_pkg::BYTES_PER_GROUP_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  output logic            tok_ready,
  input  br1_pkg::token_t tok,
  br1_group_if.source     code_groups
);
  import br1_pkg::*;

  localparam int CW = $clog2(GROUP + 1);

  logic [7:0]    gbuf [GROUP];
  logic [7:0]    gview [GROUP_MAX];
  logic [CW-1:0] gcnt;
  logic          out_valid;
  logic [7:0]    obyte [GROUP_MAX];
  logic [3:0]    ocount;
  logic          olast;
  logic          odone;
  logic          full;
  logic          out_free;
  logic          take;
  logic          load;

  assign full      = (gcnt == CW'(GROUP));
  assign out_free  = !out_valid || code_groups.ready;
  assign tok_ready = tok.is_end ? (gcnt == '0 || out_free) : (!full || out_free);
  assign take      = tok_valid && tok_ready;
  assign load      = take && (tok.is_end ? (gcnt != '0) : full);

  for (genvar k = 0; k < GROUP_MAX; k++) begin : g_view
    if (k < GROUP) begin : g_used
      assign gview[k] = (CW'(k) < gcnt) ? gbuf[k] : 8'h00;
    end else begin : g_unused
      assign gview[k] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (code_groups.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (tok.is_end) begin
          gcnt <= '0;
        end else if (full) begin
          gcnt <= CW'(1);
        end else begin
          gcnt <= gcnt + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !tok.is_end) begin
      for (int k = 0; k < GROUP; k++) begin
        if (full ? (k == 0) : (gcnt == CW'(k))) begin
          gbuf[k] <= tok.value;
        end
      end
    end
    if (load) begin
      for (int k = 0; k < GROUP_MAX; k++) begin
        obyte[k] <= gview[k];
      end
      ocount <= 4'(gcnt);
      olast  <= tok.is_end;
      odone  <= tok.is_end && tok.row_done;
    end
  end

  assign code_groups.valid      = out_valid;
  assign code_groups.out_byte_0 = obyte[0];
  assign code_groups.out_byte_1 = obyte[1];
  assign code_groups.out_byte_2 = obyte[2];
  assign code_groups.out_byte_3 = obyte[3];
  assign code_groups.out_byte_4 = obyte[4];
  assign code_groups.out_byte_5 = obyte[5];
  assign code_groups.out_byte_6 = obyte[6];
  assign code_groups.out_byte_7 = obyte[7];
  assign code_groups.byte_count = ocount;
  assign code_groups.group_last = olast;
  assign code_groups.row_done   = odone;

endmodule

>>> sv/byterun1_row_encoder.sv
// ByteRun1 (PackBits) row encoder, top level.
// Depends on br1_pkg, br1_byte_if, br1_group_if, br1_front, br1_cmd_fifo,
// br1_back, br1_packer and assert_macros.svh.

// The encoder takes one row byte per transaction, with row_last on the final
// byte of each row, and returns ByteRun1 code in groups of up to
// BYTES_PER_GROUP bytes; group_last marks the final group caused by an input
// transaction and row_done the final group of a row. A run of three or more
// equal bytes becomes a repeat block and everything else a literal block, each
// cut into chunks of at most 128 bytes counted from the front. The front end
// classifies each byte combinationally and queues one command for it in a
// four-entry queue, so input is taken every cycle while the queue has room.
// The back end executes one command at a time: it steps through a middle
// flush, a repeat block, two runs of literal bytes, an end flush and the end
// mark, writes each literal byte into the 128-byte literal store and sends
// each code byte as a token before it takes the next command. The literal
// store needs no clearing after reset.
`include "assert_macros.svh"

module byterun1_row_encoder #(
  parameter int BYTES_PER_GROUP = br1_pkg::BYTES_PER_GROUP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  br1_byte_if.sink    row_bytes,
  br1_group_if.source code_groups
);
  import br1_pkg::*;

  logic   cmd_valid;
  logic   cmd_ready;
  cmd_t   cmd_front;
  logic   cmd_pop_valid;
  logic   cmd_pop_ready;
  cmd_t   cmd_back;
  logic   tok_valid;
  logic   tok_ready;
  token_t tok;

  br1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .row_bytes (row_bytes),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd_front)
  );

  br1_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd_front),
    .pop_valid  (cmd_pop_valid),
    .pop_ready  (cmd_pop_ready),
    .pop_data   (cmd_back)
  );

  br1_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_pop_valid),
    .cmd_ready (cmd_pop_ready),
    .cmd_in    (cmd_back),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  br1_packer #(
    .GROUP (BYTES_PER_GROUP)
  ) u_packer (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .tok         (tok),
    .code_groups (code_groups)
  );

  `ASSERT_IMPLY(a_count_range, clk, rst, code_groups.valid, code_groups.byte_count != 4'd0 && code_groups.byte_count <= 4'(BYTES_PER_GROUP))
  `ASSERT_IMPLY(a_short_only_last, clk, rst, code_groups.valid && !code_groups.group_last, code_groups.byte_count == 4'(BYTES_PER_GROUP))
  `ASSERT_IMPLY(a_done_is_last, clk, rst, code_groups.valid && code_groups.row_done, code_groups.group_last)
  `ASSERT_NEXT(a_row_end_group, clk, rst, tok_valid && tok_ready && tok.is_end && tok.row_done, code_groups.valid && code_groups.row_done)

endmodule
